>>> hw/rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and the coil lookup for the stepper phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  // Sequence and counter geometry
  localparam int unsigned SeqLength  = 8;
  localparam int unsigned PhaseW     = $clog2(SeqLength);
  localparam int unsigned TickW      = 10;
  localparam int unsigned CountW     = 24;
  localparam int unsigned ModeW      = 2;
  localparam int unsigned CoilW      = 4;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 4;

  localparam logic [TickW-1:0]  TickMax  = {TickW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Register reset values
  localparam logic [ModeW-1:0]  ModeRst     = 2'd2;
  localparam logic              ReverseRst  = 1'b1;
  localparam logic [TickW-1:0]  IntervalRst = 10'd3;
  localparam logic [CountW-1:0] LimitRst    = 24'd10240;

  // Drive modes; the unused code drives as half-step
  typedef enum logic [ModeW-1:0] {
    MODE_WAVE = 2'd0,
    MODE_FULL = 2'd1,
    MODE_HALF = 2'd2
  } step_mode_e;

  // Register word indexes
  typedef enum logic [1:0] {
    REG_STEP_MODE = 2'd0,
    REG_REVERSE   = 2'd1,
    REG_INTERVAL  = 2'd2,
    REG_LIMIT     = 2'd3
  } reg_idx_e;

  // Configuration bundle from the register file to the sequencer
  typedef struct packed {
    logic [ModeW-1:0]  step_mode;
    logic              reverse_direction;
    logic [TickW-1:0]  step_interval_ms;
    logic [CountW-1:0] step_limit;
  } cfg_t;

  // Half-step coil table, bit3 IN1 down to bit0 IN4
  function automatic logic [CoilW-1:0] coil_lookup(input logic [PhaseW-1:0] idx);
    logic [CoilW-1:0] pat;
    unique case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sps_if.sv
// ----------------------------------------------------------------------------
// sps_if
// Valid/ready channels of the stepper phase sequencer: tick in, step out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_tick_if;
  logic valid;
  logic ready;
  logic ms_tick;

  modport source (output valid, output ms_tick, input ready);
  modport sink   (input valid, input ms_tick, output ready);
endinterface

interface sps_step_if;
  import sps_pkg::*;

  logic              valid;
  logic              ready;
  logic [CoilW-1:0]  coil_pattern;
  logic [CountW-1:0] steps_done;

  modport source (output valid, output coil_pattern, output steps_done, input ready);
  modport sink   (input valid, input coil_pattern, input steps_done, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sps_apb_regs.sv
// ----------------------------------------------------------------------------
// sps_apb_regs
// APB register file holding mode, direction, step interval and step limit.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_apb_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sps_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [sps_pkg::ApbDataW-1:0]  pwdata,
  output logic      [sps_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready,
  output sps_pkg::cfg_t                      cfg_o
);
  import sps_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_o   = cfg_q;

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_mode         <= ModeRst;
      cfg_q.reverse_direction <= ReverseRst;
      cfg_q.step_interval_ms  <= IntervalRst;
      cfg_q.step_limit        <= LimitRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STEP_MODE: cfg_q.step_mode         <= pwdata[ModeW-1:0];
        REG_REVERSE:   cfg_q.reverse_direction <= pwdata[0];
        REG_INTERVAL:  cfg_q.step_interval_ms  <= pwdata[TickW-1:0];
        REG_LIMIT:     cfg_q.step_limit        <= pwdata[CountW-1:0];
        default:       ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_STEP_MODE: prdata = ApbDataW'(cfg_q.step_mode);
      REG_REVERSE:   prdata = ApbDataW'(cfg_q.reverse_direction);
      REG_INTERVAL:  prdata = ApbDataW'(cfg_q.step_interval_ms);
      REG_LIMIT:     prdata = ApbDataW'(cfg_q.step_limit);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/stepper_phase_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Tick-driven unipolar stepper sequencer: wave, full-step and half-step drive.
// ----------------------------------------------------------------------------
// Usage:
//   tick_i carries one millisecond tick per transaction (ms_tick 0 means no
//   time passed). Each transaction yields zero or one step transaction on
//   step_o with the 4-bit coil pattern and the saturating half-step count.
//   The registers (mode, direction, interval, limit) are written over APB,
//   by the user only while the block is idle; the block does not enforce it.
// Throughput and step output:
//   One tick transaction per clock while tick_i.ready is high. A step is
//   registered in the output (or skid) register as the counters update.
// Stalls:
//   A two-entry output stage (output register plus skid register) keeps
//   tick_i ready while one step waits on step_o; tick_i.ready drops only
//   when both entries hold a step.
// Reset:
//   Phase, tick and step counters clear to zero, the output stage empties,
//   and the registers take half-step, reverse, interval 3, limit 10240.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sps_tick_if.sink                           tick_i,
  sps_step_if.source                         step_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sps_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [sps_pkg::ApbDataW-1:0]  pwdata,
  output logic      [sps_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready
);
  import sps_pkg::*;

  cfg_t cfg;

  sps_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic [CountW-1:0] done_q, done_d;

  // Output stage: main register and skid register
  logic              out_valid_q, skid_valid_q;
  logic [CoilW-1:0]  out_coil_q, skid_coil_q;
  logic [CountW-1:0] out_done_q, skid_done_q;

  logic              accept, fire, push, pop;
  logic [TickW-1:0]  tick_new;
  logic [PhaseW-1:0] idx_fwd, idx;
  logic              half_mode;
  logic [CountW:0]   done_sum;
  logic [CoilW-1:0]  coil_new;

  assign tick_i.ready = !skid_valid_q;
  assign accept       = tick_i.valid && tick_i.ready;

  // Tick count, saturating
  assign tick_new = (tick_i.ms_tick && (tick_q != TickMax)) ? tick_q + 1'b1 : tick_q;
  assign fire     = (done_q < cfg.step_limit) && (tick_new >= cfg.step_interval_ms);
  assign push     = accept && fire;
  assign pop      = out_valid_q && step_o.ready;

  // Table index per drive mode; unused mode code drives as half-step
  always_comb begin
    half_mode = 1'b0;
    idx_fwd   = phase_q;
    if (cfg.step_mode == MODE_WAVE) begin
      idx_fwd = {phase_q[1:0], 1'b0};
    end else if (cfg.step_mode == MODE_FULL) begin
      idx_fwd = {phase_q[1:0], 1'b1};
    end else begin
      half_mode = 1'b1;
    end
  end

  // Reverse steps back one table entry and counts the phase down
  assign idx      = cfg.reverse_direction ? idx_fwd - 1'b1 : idx_fwd;
  assign coil_new = coil_lookup(idx);
  assign done_sum = {1'b0, done_q} + (half_mode ? (CountW+1)'(1) : (CountW+1)'(2));

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    done_d  = done_q;
    if (accept) begin
      tick_d = tick_new;
      if (fire) begin
        tick_d  = '0;
        phase_d = cfg.reverse_direction ? phase_q - 1'b1 : phase_q + 1'b1;
        done_d  = done_sum[CountW] ? CountMax : done_sum[CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      tick_q  <= '0;
      done_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      done_q  <= done_d;
    end
  end

  // Output stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Output stage payload
  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_coil_q <= skid_coil_q;
      out_done_q <= skid_done_q;
    end else if (push && (pop || !out_valid_q)) begin
      out_coil_q <= coil_new;
      out_done_q <= done_d;
    end
    if (push && out_valid_q && !pop) begin
      skid_coil_q <= coil_new;
      skid_done_q <= done_d;
    end
  end

  assign step_o.valid        = out_valid_q;
  assign step_o.coil_pattern = out_coil_q;
  assign step_o.steps_done   = out_done_q;

`ifndef SYNTHESIS
  // Skid entry is only ever filled behind an occupied output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // A step produced while the output stalls lands in the skid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !step_o.ready) |=> skid_valid_q)
    else $error("step lost while output stalled");

  // Every step moves the phase by exactly one position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> ((phase_q == PhaseW'($past(phase_q) + 1'b1)) ||
              (phase_q == PhaseW'($past(phase_q) - 1'b1))))
    else $error("phase did not advance by one on a step");

  // Step count grows on every step until it saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> ((done_q > $past(done_q)) || (done_q == CountMax)))
    else $error("step count did not advance");

  // The tick counter restarts after a step
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> (tick_q == '0))
    else $error("tick counter not cleared after a step");
`endif

endmodule

`default_nettype wire
